[rtl/core/sots_pkg.sv]
package sots_pkg;

  // Width of the tested number.
  localparam int WIDTH = 32;

  // Width of the bit counter that steps the divider through one quotient.
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // Residue modulo 4 that marks a prime needing an even exponent.
  localparam logic [1:0] RES_BAD = 2'd3;

endpackage

[rtl/core/sum_of_two_squares_test.sv]
// Sum-of-two-squares test. Each request carries one unsigned number. The block
// answers whether that number equals a*a + b*b for non-negative integers a and b.
// The answer is 1 for zero and one. It uses the prime-factor rule and factors
// by trial division. One restoring divider, shared for all work, produces one
// quotient bit per cycle. Each division is followed by an evaluation step. A
// request needs as many divisions as there are trial divisors up to the square
// root of the shrinking remainder, plus one per prime factor taken out. The
// worst case is a prime near 2^WIDTH, which needs about 2^(WIDTH/2) divisions.
// Numbers below four need a single division. The block takes one request at a
// time: in_ready is high only while it is idle. The result is held on
// out_is_sum until it is taken.
module sum_of_two_squares_test (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sots_pkg::WIDTH-1:0] in_number,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_is_sum
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } state_t;

  state_t                          state_r;
  logic [sots_pkg::WIDTH-1:0]      n_r;     // remaining cofactor
  logic [sots_pkg::WIDTH-1:0]      d_r;     // current trial divisor
  logic [sots_pkg::WIDTH-1:0]      rem_r;   // divider partial remainder
  logic [sots_pkg::WIDTH-1:0]      quo_r;   // dividend shifting out, quotient in
  logic [sots_pkg::CNT_W-1:0]      cnt_r;
  logic                            par_r;   // exponent parity of d_r
  logic                            fresh_r; // first division with this divisor
  logic                            out_valid_r;
  logic                            out_is_sum_r;

  logic [sots_pkg::WIDTH:0]        trial;
  logic                            fits;

  // One step of the restoring divider.
  assign trial = {rem_r, quo_r[sots_pkg::WIDTH-1]} - {1'b0, d_r};
  assign fits  = ~trial[sots_pkg::WIDTH];

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_is_sum = out_is_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            n_r     <= in_number;
            d_r     <= sots_pkg::WIDTH'(2);
            par_r   <= 1'b0;
            fresh_r <= 1'b1;
            rem_r   <= '0;
            quo_r   <= in_number;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (fits) begin
            rem_r <= trial[sots_pkg::WIDTH-1:0];
          end else begin
            rem_r <= {rem_r[sots_pkg::WIDTH-2:0], quo_r[sots_pkg::WIDTH-1]};
          end
          quo_r <= {quo_r[sots_pkg::WIDTH-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == sots_pkg::CNT_W'(sots_pkg::WIDTH - 1)) begin
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          // Here quo_r holds n / d and rem_r holds n % d.
          priority if (fresh_r && (d_r > quo_r)) begin
            // The divisor's square exceeds the remainder, so what is left is 1 or a prime.
            out_is_sum_r <= (n_r[1:0] != sots_pkg::RES_BAD);
            out_valid_r  <= 1'b1;
            state_r      <= ST_DONE;
          end else if (rem_r == '0) begin
            n_r     <= quo_r;
            par_r   <= ~par_r;
            fresh_r <= 1'b0;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else if (par_r && (d_r[1:0] == sots_pkg::RES_BAD)) begin
            out_is_sum_r <= 1'b0;
            out_valid_r  <= 1'b1;
            state_r      <= ST_DONE;
          end else begin
            d_r     <= d_r + 1'b1;
            par_r   <= 1'b0;
            fresh_r <= 1'b1;
            rem_r   <= '0;
            quo_r   <= n_r;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/sots_chk.sv]
module sots_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_is_sum
);

  // A result waiting to be taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_sum))
    else $error("result changed or dropped while stalled");

  // The block never offers a result while it takes a new request.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("ready for input while a result is pending");

  // An accepted request starts the divider, so no answer appears at once.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block not busy after accepting a request");

  // Taking the result returns the block to idle.
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("block not idle after result was taken");

endmodule

bind sum_of_two_squares_test sots_chk u_sots_chk (.*);
